>>> hw/rtl/mp_pkg.sv
// Shared types and constants for the modular power block.
`default_nettype none

package mp_pkg;

  // Program counter width of the control store.
  localparam int unsigned PC_W = 4;

  // Value width of residues and of the modulus.
  localparam int unsigned VAL_W = 31;

  // Reset value of the modulus register.
  localparam logic [VAL_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Datapath actions, one per control word.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_START_RED,
    ACT_LOAD_B,
    ACT_START_SQ,
    ACT_START_MB,
    ACT_LOAD_ACC,
    ACT_SHIFT,
    ACT_WRITE_OUT
  } act_t;

  // Jump conditions; a taken jump loads the target, otherwise the step counter advances.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SMALL_MOD,
    COND_MUL_BUSY,
    COND_CNT_ZERO,
    COND_BIT_CLEAR,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic no_input;
    logic small_mod;
    logic mul_busy;
    logic cnt_zero;
    logic bit_clear;
    logic out_blocked;
  } status_t;

  // Program addresses.
  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_RED      = 4'd1;
  localparam logic [PC_W-1:0] STEP_RED_WAIT = 4'd2;
  localparam logic [PC_W-1:0] STEP_LOAD_B   = 4'd3;
  localparam logic [PC_W-1:0] STEP_LOOP     = 4'd4;
  localparam logic [PC_W-1:0] STEP_SQ       = 4'd5;
  localparam logic [PC_W-1:0] STEP_SQ_WAIT  = 4'd6;
  localparam logic [PC_W-1:0] STEP_SQ_DONE  = 4'd7;
  localparam logic [PC_W-1:0] STEP_MB       = 4'd8;
  localparam logic [PC_W-1:0] STEP_MB_WAIT  = 4'd9;
  localparam logic [PC_W-1:0] STEP_MB_DONE  = 4'd10;
  localparam logic [PC_W-1:0] STEP_NEXT     = 4'd11;
  localparam logic [PC_W-1:0] STEP_FINISH   = 4'd12;
  localparam logic [PC_W-1:0] STEP_RETURN   = 4'd13;

endpackage

`default_nettype wire

>>> hw/rtl/mp_modmul.sv
// Interleaved modular multiplier that retires two multiplier bits per cycle.
`default_nettype none

module mp_modmul
  import mp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] a,
  input  wire logic [VAL_W-1:0] b,
  input  wire logic [VAL_W-1:0] m,
  output logic                  busy,
  output logic [VAL_W-1:0]      result
);

  logic [3:0]       count;
  logic [VAL_W-1:0] r;
  logic [VAL_W:0]   bsh;
  logic [VAL_W-1:0] a_hold;
  logic [VAL_W-1:0] r_mid;
  logic [VAL_W-1:0] r_next;

  // One bit of the multiplier: r = (2r + bit*a) mod m, with r and a below m.
  function automatic logic [VAL_W-1:0] mm_step(input logic [VAL_W-1:0] rv,
                                               input logic             bv,
                                               input logic [VAL_W-1:0] av,
                                               input logic [VAL_W-1:0] mv);
    logic [VAL_W:0] t;
    logic [VAL_W:0] mx;
    mx = {1'b0, mv};
    t  = {rv, 1'b0};
    if (t >= mx) begin
      t = t - mx;
    end
    t = t + (bv ? {1'b0, av} : '0);
    if (t >= mx) begin
      t = t - mx;
    end
    return t[VAL_W-1:0];
  endfunction

  assign r_mid  = mm_step(r, bsh[VAL_W], a_hold, m);
  assign r_next = mm_step(r_mid, bsh[VAL_W-1], a_hold, m);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 4'd1;
      if (count == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r      <= '0;
      bsh    <= {1'b0, b};
      a_hold <= a;
    end else if (busy) begin
      r   <= r_next;
      bsh <= {bsh[VAL_W-2:0], 2'b00};
    end
  end

  assign result = r;

endmodule

`default_nettype wire

>>> hw/rtl/mp_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module mp_sequencer
  import mp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output ctrl_word_t   ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  // The program. Unused addresses return to the idle step.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] addr);
    ctrl_word_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (addr)
      STEP_IDLE:     w = '{act: ACT_LOAD,      cond: COND_NO_INPUT,    target: STEP_IDLE};
      STEP_RED:      w = '{act: ACT_START_RED, cond: COND_NONE,        target: STEP_IDLE};
      STEP_RED_WAIT: w = '{act: ACT_NONE,      cond: COND_MUL_BUSY,    target: STEP_RED_WAIT};
      STEP_LOAD_B:   w = '{act: ACT_LOAD_B,    cond: COND_SMALL_MOD,   target: STEP_FINISH};
      STEP_LOOP:     w = '{act: ACT_NONE,      cond: COND_CNT_ZERO,    target: STEP_FINISH};
      STEP_SQ:       w = '{act: ACT_START_SQ,  cond: COND_NONE,        target: STEP_IDLE};
      STEP_SQ_WAIT:  w = '{act: ACT_NONE,      cond: COND_MUL_BUSY,    target: STEP_SQ_WAIT};
      STEP_SQ_DONE:  w = '{act: ACT_LOAD_ACC,  cond: COND_BIT_CLEAR,   target: STEP_NEXT};
      STEP_MB:       w = '{act: ACT_START_MB,  cond: COND_NONE,        target: STEP_IDLE};
      STEP_MB_WAIT:  w = '{act: ACT_NONE,      cond: COND_MUL_BUSY,    target: STEP_MB_WAIT};
      STEP_MB_DONE:  w = '{act: ACT_LOAD_ACC,  cond: COND_NONE,        target: STEP_IDLE};
      STEP_NEXT:     w = '{act: ACT_SHIFT,     cond: COND_ALWAYS,      target: STEP_LOOP};
      STEP_FINISH:   w = '{act: ACT_WRITE_OUT, cond: COND_OUT_BLOCKED, target: STEP_FINISH};
      STEP_RETURN:   w = '{act: ACT_NONE,      cond: COND_ALWAYS,      target: STEP_IDLE};
      default:       w = '{act: ACT_NONE,      cond: COND_ALWAYS,      target: STEP_IDLE};
    endcase
    return w;
  endfunction

  assign ctrl = ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NONE:        take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = status.no_input;
      COND_SMALL_MOD:   take = status.small_mod;
      COND_MUL_BUSY:    take = status.mul_busy;
      COND_CNT_ZERO:    take = status.cnt_zero;
      COND_BIT_CLEAR:   take = status.bit_clear;
      COND_OUT_BLOCKED: take = status.out_blocked;
      default:          take = 1'b1;
    endcase
  end

  assign pc_next = take ? ctrl.target : pc + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/modular_power.sv
// Top level of the modular power block: datapath, registers and handshakes.
// The time an item takes grows with EXP_BITS and the set exponent bits, and is shorter
//   when the modulus is below two; each product holds the shared multiplier until done.
// One item at a time; the next is taken after the finish and return steps, and a finished
// result waits in an output register while the next item is taken and worked on.
// Reset (rst, synchronous, active high) clears the sequencer and valids; modulus is 1000000007.
`default_nettype none

module modular_power
  import mp_pkg::*;
#(
  parameter int unsigned EXP_BITS = 63
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input channel.
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [30:0]      base,
  input  wire logic [62:0]      exponent,
  // Result channel.
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [30:0]           power,
  // Modulus configuration channel.
  input  wire logic             modulus_valid,
  output logic                  modulus_ready,
  input  wire logic [30:0]      modulus
);

  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  // Control word from the sequencer and the status that steers its jumps.
  ctrl_word_t ctrl;
  status_t    status;

  // Datapath registers.
  logic [VAL_W-1:0]    mod_value;
  logic [VAL_W-1:0]    acc;
  logic [VAL_W-1:0]    bval;
  logic [EXP_BITS-1:0] e;
  logic [CNT_W-1:0]    cnt;

  // Shared modular multiplier.
  logic             mul_start;
  logic [VAL_W-1:0] mul_a;
  logic [VAL_W-1:0] mul_b;
  logic             mul_busy;
  logic [VAL_W-1:0] mul_result;

  logic in_xfer;
  logic out_xfer;
  logic out_load;
  logic small_mod;

  mp_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mp_modmul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (mod_value),
    .busy   (mul_busy),
    .result (mul_result)
  );

  // The block takes configuration at any time; the user must issue writes only while idle.
  assign modulus_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_value <= MODULUS_RESET;
    end else if (modulus_valid && modulus_ready) begin
      mod_value <= modulus;
    end
  end

  // A modulus of zero or one yields zero for every item.
  assign small_mod = (mod_value < 31'd2);

  // Only the load step of the program takes an input transfer, and never during reset.
  assign in_stall = rst || (ctrl.act != ACT_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // The result register may load when it is empty or being drained this cycle.
  assign out_load = (ctrl.act == ACT_WRITE_OUT) && !(out_valid && out_stall);

  always_comb begin
    status.no_input    = !in_valid;
    status.small_mod   = small_mod;
    status.mul_busy    = mul_busy;
    status.cnt_zero    = (cnt == '0);
    status.bit_clear   = !e[EXP_BITS-1];
    status.out_blocked = out_valid && out_stall;
  end

  // Operand selection for the multiplier. The base is first reduced as 1 * base mod m;
  // squares use the running value twice and the conditional step multiplies by the base.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = acc;
    mul_b     = acc;
    case (ctrl.act)
      ACT_START_RED: begin
        mul_start = 1'b1;
        mul_a     = 31'd1;
        mul_b     = bval;
      end
      ACT_START_SQ: begin
        mul_start = 1'b1;
      end
      ACT_START_MB: begin
        mul_start = 1'b1;
        mul_b     = bval;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Exponent bits are scanned from the most significant one down, one per loop pass.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bval <= base;
      e    <= exponent[EXP_BITS-1:0];
      cnt  <= CNT_W'(EXP_BITS);
      acc  <= 31'd1;
    end else begin
      case (ctrl.act)
        ACT_LOAD_B: begin
          bval <= mul_result;
        end
        ACT_LOAD_ACC: begin
          acc <= mul_result;
        end
        ACT_SHIFT: begin
          e   <= {e[EXP_BITS-2:0], 1'b0};
          cnt <= cnt - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds one finished result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      power <= small_mod ? '0 : acc;
    end
  end

  // After an input transfer the sequencer has left the load step.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // The multiplier is never restarted while it is still working.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  // A product loaded into the accumulator is always a residue below the modulus.
  a_residue: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_LOAD_ACC) && !small_mod |-> (mul_result < mod_value))
    else $error("product not reduced");

endmodule

`default_nettype wire
